// ----- hw/rtl/rolling_hash_pattern_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher_assert.svh
// assertion macros used by the checker of the pattern matcher
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH
`define ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RHPM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhpm check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RHPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhpm check failed");

`endif

// ----- hw/rtl/rhpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rhpm_pkg
// types and fixed constants of the rolling hash pattern matcher
// ----------------------------------------------------------------------------
package rhpm_pkg;

    localparam int PATTERN_BITS = 64;
    localparam int ENTRY_BYTES  = 8;
    localparam int BYTE_IDX_W   = 3;
    localparam int LENGTH_W     = 4;
    localparam int OUT_POS_W    = 32;
    localparam int COUNT_W      = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_of_text;
    } text_item_t;

    typedef struct packed {
        logic                 window_full;
        logic                 hash_hit;
        logic                 match_found;
        logic [OUT_POS_W-1:0] match_position;
        logic [COUNT_W-1:0]   match_count;
    } result_item_t;

    typedef struct packed {
        logic [ENTRY_BYTES*8-1:0] window;
        logic                     full;
        logic [OUT_POS_W-1:0]     position;
        logic                     start;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_REDUCE,
        BK_DONE
    } back_state_t;

endpackage

// ----- hw/rtl/rhpm_front.sv -----
// ----------------------------------------------------------------------------
// rhpm_front
// takes text items, shifts the window, tracks position and fills the queue
// ----------------------------------------------------------------------------
module rhpm_front #(
    parameter int MAX_PATTERN   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_stall,
    input  rhpm_pkg::text_item_t           text_item,
    input  logic [rhpm_pkg::LENGTH_W-1:0]  length,
    input  rhpm_pkg::queue_status_t        q_status,
    output logic                           push,
    output rhpm_pkg::queue_entry_t         entry
);

    logic [7:0]               window_reg  [MAX_PATTERN];
    logic [7:0]               window_next [MAX_PATTERN];
    logic [7:0]               window_base [MAX_PATTERN];
    logic [POSITION_BITS-1:0] seen_reg;
    logic [POSITION_BITS-1:0] seen_next;
    logic [POSITION_BITS-1:0] seen_base;
    logic [POSITION_BITS-1:0] pos_wide;
    logic [POSITION_BITS+rhpm_pkg::OUT_POS_W-1:0] pos_ext;
    logic                     full;

    assign text_stall = q_status.full;
    assign push       = text_valid && !q_status.full;

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            window_base[j] = text_item.start_of_text ? 8'd0 : window_reg[j];
        end
        for (int j = 0; j < MAX_PATTERN - 1; j++)
        begin
            window_next[j] = window_base[j + 1];
        end
        window_next[MAX_PATTERN - 1] = text_item.text_byte;

        seen_base = text_item.start_of_text ? '0 : seen_reg;
        seen_next = (seen_base == '1) ? seen_base : seen_base + 1'b1;
        full      = seen_next >= POSITION_BITS'(length);
        pos_wide  = full ? seen_next - POSITION_BITS'(length) : '0;
        pos_ext   = {rhpm_pkg::OUT_POS_W'(0), pos_wide};

        entry.window = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            entry.window[j*8 +: 8] = window_next[j];
        end
        entry.full     = full;
        entry.position = pos_ext[rhpm_pkg::OUT_POS_W-1:0];
        entry.start    = text_item.start_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                window_reg[j] <= 8'd0;
            end
            seen_reg <= '0;
        end
        else if (push)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                window_reg[j] <= window_next[j];
            end
            seen_reg <= seen_next;
        end
    end

endmodule

// ----- hw/rtl/rhpm_fifo.sv -----
// ----------------------------------------------------------------------------
// rhpm_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module rhpm_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rhpm_pkg::queue_entry_t  entry_in,
    input  logic                    pop,
    output rhpm_pkg::queue_entry_t  entry_out,
    output rhpm_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(rhpm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rhpm_pkg::QUEUE_DEPTH + 1);

    rhpm_pkg::queue_entry_t slot_reg [rhpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       fill_reg;

    assign entry_out    = slot_reg[rd_ptr_reg];
    assign status.full  = fill_reg == CNT_W'(rhpm_pkg::QUEUE_DEPTH);
    assign status.empty = fill_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// ----- hw/rtl/rhpm_back.sv -----
// ----------------------------------------------------------------------------
// rhpm_back
// horner hash of window and pattern with a reciprocal-multiply reduction,
// exact compare, saturating count and result register
// ----------------------------------------------------------------------------
module rhpm_back #(
    parameter int MAX_PATTERN = 8,
    parameter int RADIX       = 10,
    parameter int MODULUS     = 91
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rhpm_pkg::queue_status_t           q_status,
    output logic                              pop,
    input  rhpm_pkg::queue_entry_t            entry_in,
    input  logic [rhpm_pkg::LENGTH_W-1:0]     length,
    input  logic [rhpm_pkg::PATTERN_BITS-1:0] pattern_bytes,
    output logic                              result_valid,
    input  logic                              result_stall,
    output rhpm_pkg::result_item_t            result_item
);

    localparam int HASH_W = $clog2(MODULUS);
    localparam int QB     = $clog2(RADIX + 256);
    localparam int VW     = HASH_W + QB;
    localparam int SW     = 2;
    localparam int KW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int MU     = (1 << VW) / MODULUS;

    rhpm_pkg::back_state_t  state_reg, state_next;
    rhpm_pkg::queue_entry_t entry_reg, entry_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [SW-1:0]          step_reg, step_next;
    logic [HASH_W-1:0]      th_reg, th_next;
    logic [HASH_W-1:0]      ph_reg, ph_next;
    logic [VW-1:0]          rem_t_reg, rem_t_next;
    logic [VW-1:0]          rem_p_reg, rem_p_next;
    logic [QB-1:0]          quot_t_reg, quot_t_next;
    logic [QB-1:0]          quot_p_reg, quot_p_next;
    logic                   eq_reg, eq_next;
    logic [rhpm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    rhpm_pkg::result_item_t out_item_reg, out_item_next;

    logic [rhpm_pkg::LENGTH_W-1:0]   win_idx;
    logic [rhpm_pkg::BYTE_IDX_W-1:0] pat_idx;
    logic [7:0]                      wbyte;
    logic [7:0]                      pbyte;
    logic [2*VW-1:0]                 prod_t;
    logic [2*VW-1:0]                 prod_p;
    logic [VW-1:0]                   red_t;
    logic [VW-1:0]                   red_p;
    logic                            last_k;
    logic                            hit;
    logic                            match;
    logic [rhpm_pkg::COUNT_W-1:0]    count_base;
    logic [rhpm_pkg::COUNT_W-1:0]    count_new;

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        win_idx = rhpm_pkg::LENGTH_W'(MAX_PATTERN) - length + rhpm_pkg::LENGTH_W'(k_reg);
        pat_idx = rhpm_pkg::BYTE_IDX_W'(k_reg);
        wbyte   = entry_reg.window[win_idx[rhpm_pkg::BYTE_IDX_W-1:0]*8 +: 8];
        pbyte   = pattern_bytes[pat_idx*8 +: 8];
        prod_t  = (2*VW)'(rem_t_reg) * (2*VW)'(MU);
        prod_p  = (2*VW)'(rem_p_reg) * (2*VW)'(MU);
        red_t   = (rem_t_reg >= VW'(MODULUS)) ? rem_t_reg - VW'(MODULUS) : rem_t_reg;
        red_p   = (rem_p_reg >= VW'(MODULUS)) ? rem_p_reg - VW'(MODULUS) : rem_p_reg;
        last_k  = rhpm_pkg::LENGTH_W'(k_reg) == length - 1'b1;
        hit     = entry_reg.full && (th_reg == ph_reg);
        match   = hit && eq_reg;
        count_base = entry_reg.start ? '0 : count_reg;
        count_new  = (match && count_base != '1) ? count_base + 1'b1 : count_base;

        state_next     = state_reg;
        entry_next     = entry_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        th_next        = th_reg;
        ph_next        = ph_reg;
        rem_t_next     = rem_t_reg;
        rem_p_next     = rem_p_reg;
        quot_t_next    = quot_t_reg;
        quot_p_next    = quot_p_reg;
        eq_next        = eq_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rhpm_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    entry_next = entry_in;
                    th_next    = '0;
                    ph_next    = '0;
                    k_next     = '0;
                    eq_next    = 1'b1;
                    state_next = rhpm_pkg::BK_LOAD;
                end
            end
            rhpm_pkg::BK_LOAD:
            begin
                rem_t_next = VW'(RADIX) * VW'(th_reg) + VW'(wbyte);
                rem_p_next = VW'(RADIX) * VW'(ph_reg) + VW'(pbyte);
                eq_next    = eq_reg && (wbyte == pbyte);
                step_next  = SW'(2);
                state_next = rhpm_pkg::BK_REDUCE;
            end
            rhpm_pkg::BK_REDUCE:
            begin
                if (step_reg == SW'(2))
                begin
                    // quotient estimate, low by at most one
                    quot_t_next = prod_t[VW +: QB];
                    quot_p_next = prod_p[VW +: QB];
                    step_next   = SW'(1);
                end
                else if (step_reg == SW'(1))
                begin
                    rem_t_next = rem_t_reg - VW'(quot_t_reg) * VW'(MODULUS);
                    rem_p_next = rem_p_reg - VW'(quot_p_reg) * VW'(MODULUS);
                    step_next  = '0;
                end
                else
                begin
                    th_next = red_t[HASH_W-1:0];
                    ph_next = red_p[HASH_W-1:0];
                    if (last_k)
                    begin
                        state_next = rhpm_pkg::BK_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = rhpm_pkg::BK_LOAD;
                    end
                end
            end
            rhpm_pkg::BK_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.window_full    = entry_reg.full;
                    out_item_next.hash_hit       = hit;
                    out_item_next.match_found    = match;
                    out_item_next.match_position = entry_reg.position;
                    out_item_next.match_count    = count_new;
                    count_next                   = count_new;
                    state_next                   = rhpm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rhpm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rhpm_pkg::BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        k_reg        <= k_next;
        step_reg     <= step_next;
        th_reg       <= th_next;
        ph_reg       <= ph_next;
        rem_t_reg    <= rem_t_next;
        rem_p_reg    <= rem_p_next;
        quot_t_reg   <= quot_t_next;
        quot_p_reg   <= quot_p_next;
        eq_reg       <= eq_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ----- hw/rtl/rolling_hash_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher
// rabin-karp matcher over a byte stream with configurable pattern
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  text      in         text_valid/text_stall   rhpm_pkg::text_item_t
//  result    out        result_valid/result_stall rhpm_pkg::result_item_t
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  the front takes one item per cycle into a two-entry queue, text stalls when it is full
//  the back works on one item at a time: a pop, then per pattern byte a horner
//  multiply-add and a reciprocal reduction in three steps, then the result
//  rst_n clears window, position, count and queue; pattern resets to length 1
//  a stalled result holds in its register while the back finishes the next item
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher #(
    parameter int MAX_PATTERN   = 8,
    parameter int RADIX         = 10,
    parameter int MODULUS       = 91,
    parameter int POSITION_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 text_valid,
    output logic                                 text_stall,
    input  rhpm_pkg::text_item_t                 text_item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output rhpm_pkg::result_item_t               result_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rhpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rhpm_pkg::PATTERN_BITS-1:0]    cfg_data
);

    logic [rhpm_pkg::PATTERN_BITS-1:0] pattern_bytes_reg, pattern_bytes_next;
    logic [rhpm_pkg::LENGTH_W-1:0]     pattern_length_reg, pattern_length_next;
    logic [rhpm_pkg::LENGTH_W-1:0]     length;
    rhpm_pkg::queue_status_t           q_status;
    rhpm_pkg::queue_entry_t            push_entry;
    rhpm_pkg::queue_entry_t            pop_entry;
    logic                              push;
    logic                              pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pattern_bytes_next  = pattern_bytes_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rhpm_pkg::CFG_PATTERN_BYTES:  pattern_bytes_next = cfg_data;
                rhpm_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_next = cfg_data[rhpm_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= rhpm_pkg::LENGTH_W'(1);
        end
        else
        begin
            pattern_bytes_reg  <= pattern_bytes_next;
            pattern_length_reg <= pattern_length_next;
        end
    end

    // length in use, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            length = rhpm_pkg::LENGTH_W'(1);
        end
        else if (pattern_length_reg > rhpm_pkg::LENGTH_W'(MAX_PATTERN))
        begin
            length = rhpm_pkg::LENGTH_W'(MAX_PATTERN);
        end
        else
        begin
            length = pattern_length_reg;
        end
    end

    rhpm_front #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .length     (length),
        .q_status   (q_status),
        .push       (push),
        .entry      (push_entry)
    );

    rhpm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (push_entry),
        .pop       (pop),
        .entry_out (pop_entry),
        .status    (q_status)
    );

    rhpm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .RADIX       (RADIX),
        .MODULUS     (MODULUS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop           (pop),
        .entry_in      (pop_entry),
        .length        (length),
        .pattern_bytes (pattern_bytes_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_item   (result_item)
    );

endmodule

// ----- hw/rtl/rhpm_checker.sv -----
// ----------------------------------------------------------------------------
// rhpm_checker
// port-level checks on the result channel of the pattern matcher
// ----------------------------------------------------------------------------
`include "rolling_hash_pattern_matcher_assert.svh"

module rhpm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input rhpm_pkg::result_item_t result_item
);

    `RHPM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_item))
    `RHPM_ASSERT_IMPLY(a_flag_order, result_valid, (!result_item.match_found || result_item.hash_hit) && (!result_item.hash_hit || result_item.window_full))
    `RHPM_ASSERT_IMPLY(a_position_idle, result_valid && !result_item.window_full, result_item.match_position == '0)
    `RHPM_ASSERT_IMPLY(a_count_nonzero, result_valid && result_item.match_found, result_item.match_count != '0)

endmodule

bind rolling_hash_pattern_matcher rhpm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the rolling hash pattern matcher against a predictor of its own:
// every text item accepted is scanned by the predictor and the expected
// result is queued, every result taken from the block is compared with the
// oldest one waiting; directed texts come first, then random phases with
// fresh pattern settings, random idling on both sides and one long hold-off
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_PAT     = 8;
    localparam int HASH_RADIX  = 10;
    localparam int HASH_MOD    = 91;
    localparam int POS_W       = 32;
    localparam int QUIET_LIMIT = 5000;
    localparam int TEXT_TARGET = 1300;

    localparam logic [rhpm_pkg::CFG_INDEX_W-1:0] CFG_SPARE    = 2'd2;
    localparam logic [rhpm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mode_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   text_valid   = 1'b0;
    logic                   text_stall;
    rhpm_pkg::text_item_t   text_item    = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    rhpm_pkg::result_item_t result_item;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [rhpm_pkg::CFG_INDEX_W-1:0]  cfg_index = rhpm_pkg::CFG_PATTERN_BYTES;
    logic [rhpm_pkg::PATTERN_BITS-1:0] cfg_data  = '0;

    // predictor state
    logic [rhpm_pkg::PATTERN_BITS-1:0] pattern_reg;
    logic [rhpm_pkg::LENGTH_W-1:0]     length_reg;
    logic [7:0]                        window [MAX_PAT];
    int unsigned                       text_hash;
    int unsigned                       pattern_hash;
    int unsigned                       top_power;
    logic [POS_W-1:0]                  bytes_seen;
    logic [rhpm_pkg::COUNT_W-1:0]      match_total;

    rhpm_pkg::text_item_t   text_to_send [$];
    rhpm_pkg::result_item_t awaited_results [$];

    idle_mode_t tx_mode = IDLE_NONE;
    idle_mode_t rx_mode = IDLE_NONE;
    int unsigned tx_gap;
    int unsigned rx_wait;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned quiet_cycles;

    int items_queued;
    int items_sent;
    int texts_started;
    int results_checked;
    int matches_seen;
    int collisions_seen;
    int mismatch_count;
    int reg_writes;

    rolling_hash_pattern_matcher #(
        .MAX_PATTERN  (MAX_PAT),
        .RADIX        (HASH_RADIX),
        .MODULUS      (HASH_MOD),
        .POSITION_BITS(POS_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_item   (text_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item (result_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned live_length();
        if (length_reg == 0)
            return 1;
        if (length_reg > MAX_PAT)
            return MAX_PAT;
        return int'(length_reg);
    endfunction

    function automatic void rehash();
        int unsigned n;
        n = live_length();
        pattern_hash = 0;
        text_hash    = 0;
        top_power    = 1 % HASH_MOD;
        for (int k = 0; k < n; k++)
        begin
            pattern_hash = (HASH_RADIX * pattern_hash + pattern_reg[8*k +: 8]) % HASH_MOD;
            text_hash    = (HASH_RADIX * text_hash + window[MAX_PAT-n+k]) % HASH_MOD;
            if (k + 1 < n)
                top_power = (HASH_RADIX * top_power) % HASH_MOD;
        end
    endfunction

    function automatic void apply_reg(input logic [rhpm_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [rhpm_pkg::PATTERN_BITS-1:0] val);
        if (idx == rhpm_pkg::CFG_PATTERN_BYTES)
            pattern_reg = val;
        else if (idx == rhpm_pkg::CFG_PATTERN_LENGTH)
            length_reg = val[rhpm_pkg::LENGTH_W-1:0];
        else
            return;
        rehash();
    endfunction

    // rolls one byte into the window and works out the result it gives
    function automatic rhpm_pkg::result_item_t scan_byte(input rhpm_pkg::text_item_t it);
        rhpm_pkg::result_item_t r;
        int unsigned  n;
        int unsigned  drop;
        logic         same;
        n = live_length();
        if (it.start_of_text)
        begin
            foreach (window[k])
                window[k] = 8'h00;
            text_hash   = 0;
            bytes_seen  = '0;
            match_total = '0;
        end
        drop      = (window[MAX_PAT-n] * top_power) % HASH_MOD;
        text_hash = ((text_hash + HASH_MOD - drop) % HASH_MOD * HASH_RADIX
                     + it.text_byte) % HASH_MOD;
        for (int k = 0; k < MAX_PAT - 1; k++)
            window[k] = window[k+1];
        window[MAX_PAT-1] = it.text_byte;
        if (bytes_seen != '1)
            bytes_seen++;
        r = '0;
        r.window_full = (bytes_seen >= n);
        if (r.window_full)
        begin
            r.match_position = bytes_seen - n;
            r.hash_hit       = (text_hash == pattern_hash);
            if (r.hash_hit)
            begin
                same = 1'b1;
                for (int k = 0; k < n; k++)
                    if (window[MAX_PAT-n+k] != pattern_reg[8*k +: 8])
                        same = 1'b0;
                if (same && match_total != '1)
                    match_total++;
                r.match_found = same;
            end
        end
        r.match_count = match_total;
        return r;
    endfunction

    function automatic int unsigned draw_wait(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 16);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic s);
        rhpm_pkg::text_item_t t;
        t.text_byte     = b;
        t.start_of_text = s;
        text_to_send.push_back(t);
        items_queued++;
    endfunction

    task automatic write_reg(input logic [rhpm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rhpm_pkg::PATTERN_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (text_to_send.size() != 0 || text_valid || awaited_results.size() != 0);
    endtask

    // text driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                awaited_results.push_back(scan_byte(text_item));
                items_sent++;
                if (text_item.start_of_text)
                    texts_started++;
            end
            if (!text_valid || !text_stall)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    text_valid <= 1'b0;
                end
                else if (text_to_send.size() != 0)
                begin
                    text_item  <= text_to_send.pop_front();
                    text_valid <= 1'b1;
                    tx_gap = draw_wait(tx_mode);
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        rhpm_pkg::result_item_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_left != 0)
                hold_left--;
            else if (result_valid && result_stall && rx_wait != 0)
                rx_wait--;
            if (result_valid && !result_stall)
            begin
                results_checked++;
                rx_wait = draw_wait(rx_mode);
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with nothing awaited", results_checked);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.match_found)
                        matches_seen++;
                    if (want.hash_hit && !want.match_found)
                        collisions_seen++;
                    if (result_item !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected full %b hit %b match %b pos %0d ",
                                      "count %0d, got full %b hit %b match %b pos %0d count %0d"},
                                     results_checked, want.window_full, want.hash_hit,
                                     want.match_found, want.match_position, want.match_count,
                                     result_item.window_full, result_item.hash_hit,
                                     result_item.match_found, result_item.match_position,
                                     result_item.match_count);
                    end
                end
            end
            // long hold-off so the block backs up and stalls its input
            if (!hold_done && results_checked >= 300 && text_to_send.size() >= 20)
            begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            result_stall <= (hold_left != 0) || (rx_wait != 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && !text_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results still awaited",
                         QUIET_LIMIT, awaited_results.size());
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int          phase;
        int          n;
        int          target;
        int          choice;
        int          flip;
        int unsigned plen;
        logic [7:0]  sym [3];
        logic [rhpm_pkg::PATTERN_BITS-1:0] pat_val;
        logic [rhpm_pkg::PATTERN_BITS-1:0] len_val;
        logic [3:0]  len_code;
        logic [3:0]  fixed_len [6];

        fixed_len = '{4'd0, 4'd15, 4'd9, 4'd1, 4'd8, 4'd3};
        pattern_reg = '0;
        length_reg  = 4'd1;
        foreach (window[k])
            window[k] = 8'h00;
        bytes_seen  = '0;
        match_total = '0;
        rehash();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern: a single zero byte, multiples of the modulus collide
        @(negedge clk);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5B, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hB6, 1'b0);
        drain();

        // two-byte pattern set mid-text, then a restart
        tx_mode = IDLE_FULL;
        write_reg(rhpm_pkg::CFG_PATTERN_BYTES, 64'h6261);
        write_reg(rhpm_pkg::CFG_PATTERN_LENGTH, 64'd2);
        @(negedge clk);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h61, 1'b1);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        drain();

        // full-length pattern of ones, a text too short, then a full match
        rx_mode = IDLE_FULL;
        write_reg(rhpm_pkg::CFG_PATTERN_LENGTH, 64'd8);
        write_reg(rhpm_pkg::CFG_PATTERN_BYTES, '1);
        @(negedge clk);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        for (int k = 0; k < 7; k++)
            queue_byte(8'hFF, 1'b0);
        drain();

        for (phase = 0; items_queued < TEXT_TARGET; phase++)
        begin
            tx_mode = idle_mode_t'($urandom_range(0, 2));
            rx_mode = idle_mode_t'($urandom_range(0, 2));
            len_code = (phase < 6) ? fixed_len[phase] : 4'($urandom_range(0, 15));
            plen = (len_code == 0) ? 1 : ((len_code > MAX_PAT) ? MAX_PAT : len_code);
            for (int k = 0; k < 3; k++)
                sym[k] = 8'($urandom_range(0, 255));
            if (phase == 0)
                sym[0] = 8'hFF;
            else if (phase == 1)
                sym[0] = 8'h00;
            for (int k = 0; k < MAX_PAT; k++)
                pat_val[8*k +: 8] = sym[(phase < 2) ? 0 : $urandom_range(0, 2)];
            len_val = {$urandom, $urandom};
            len_val[3:0] = len_code;

            drain();
            if ($urandom_range(0, 1))
            begin
                write_reg(rhpm_pkg::CFG_PATTERN_LENGTH, len_val);
                write_reg(rhpm_pkg::CFG_PATTERN_BYTES, pat_val);
            end
            else
            begin
                write_reg(rhpm_pkg::CFG_PATTERN_BYTES, pat_val);
                write_reg(rhpm_pkg::CFG_PATTERN_LENGTH, len_val);
            end
            if (phase == 2)
            begin
                write_reg(CFG_SPARE, {$urandom, $urandom});
                write_reg(CFG_SPARE_HI, '1);
            end
            else if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE : CFG_SPARE_HI, {$urandom, $urandom});

            @(negedge clk);
            n = 0;
            target = $urandom_range(60, 140);
            if ($urandom_range(0, 1))
            begin
                queue_byte(sym[$urandom_range(0, 2)], 1'b1);
                n++;
            end
            while (n < target)
            begin
                choice = $urandom_range(0, 19);
                if (choice < 7)
                begin
                    for (int k = 0; k < plen; k++)
                        queue_byte(pat_val[8*k +: 8], 1'b0);
                    n += plen;
                end
                else if (choice < 9)
                begin
                    // pattern copy with one byte spoilt
                    flip = $urandom_range(0, plen - 1);
                    for (int k = 0; k < plen; k++)
                        queue_byte((k == flip) ? pat_val[8*k +: 8] ^ 8'($urandom_range(1, 255))
                                               : pat_val[8*k +: 8], 1'b0);
                    n += plen;
                end
                else if (choice < 17)
                begin
                    queue_byte(sym[$urandom_range(0, 2)], 1'b0);
                    n++;
                end
                else if (choice < 19)
                begin
                    queue_byte(8'($urandom_range(0, 255)), 1'b0);
                    n++;
                end
                else
                begin
                    queue_byte(8'($urandom_range(0, 255)), 1'b1);
                    n++;
                end
            end
        end

        drain();
        repeat (200) @(posedge clk);
        $display("%0d text items in %0d restarts over %0d random pattern settings, %0d reg writes",
                 items_sent, texts_started, phase, reg_writes);
        $display("%0d results checked: %0d confirmed matches, %0d hash collisions, %0d mismatches",
                 results_checked, matches_seen, collisions_seen, mismatch_count);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
